>>> design/unsigned_to_ascii_digits_macros.svh
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits assertion macros
// Shorthand for the concurrent checks on the number-to-text converter.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_TO_ASCII_DIGITS_MACROS_SVH
`define UNSIGNED_TO_ASCII_DIGITS_MACROS_SVH

// check that is switched off while reset is held
`define UAD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also runs during reset
`define UAD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/uad_pkg.sv
// ----------------------------------------------------------------------------
// uad_pkg
// Types and constants shared by the number-to-text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package uad_pkg;

    // stream widths
    localparam int S_TDATA_W = 72;  // value, size_mode, alt_form, zero pad
    localparam int S_TUSER_W = 2;   // kind
    localparam int M_TDATA_W = 8;   // char_out

    localparam int VAL_W      = 64;
    localparam int NUM_DIGITS = 22;            // octal of 64 bits is the longest
    localparam int DIG_W      = 4 * NUM_DIGITS;
    localparam int REM_W      = 5;
    localparam int STEP_W     = 5;

    // kind codes
    localparam logic [1:0] KIND_DEC  = 2'd0;
    localparam logic [1:0] KIND_OCT  = 2'd1;
    localparam logic [1:0] KIND_HEXL = 2'd2;
    localparam logic [1:0] KIND_HEXU = 2'd3;

    // length modifier codes (the unused code behaves like SIZE_32)
    localparam logic [1:0] SIZE_32 = 2'd0;
    localparam logic [1:0] SIZE_64 = 2'd1;
    localparam logic [1:0] SIZE_16 = 2'd2;

    // shift-add-3 step counts per width, four bits per step
    localparam logic [STEP_W-1:0] STEPS_16 = 5'd4;
    localparam logic [STEP_W-1:0] STEPS_32 = 5'd8;
    localparam logic [STEP_W-1:0] STEPS_64 = 5'd16;

    // characters
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] ASCII_LA   = 8'h61;
    localparam logic [7:0] ASCII_LF   = 8'h66;
    localparam logic [7:0] ASCII_UA   = 8'h41;
    localparam logic [7:0] ASCII_UF   = 8'h46;
    localparam logic [7:0] ASCII_LX   = 8'h78;
    localparam logic [7:0] ASCII_UX   = 8'h58;

    // classified word passed from front to back
    typedef struct packed {
        logic [1:0]        kind;
        logic [VAL_W-1:0]  value;   // already cut to the selected length
        logic [STEP_W-1:0] steps;   // decimal conversion steps
        logic              prefix;  // alternate form applies
    } cmd_t;

endpackage

`default_nettype wire

>>> design/uad_front.sv
// ----------------------------------------------------------------------------
// uad_front
// Accepts input words, cuts the value to its length and queues a command.
// ----------------------------------------------------------------------------
`default_nettype none

module uad_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [uad_pkg::S_TDATA_W-1:0]   s_tdata,  // value[63:0], size_mode[65:64],
                                                      // alt_form[66], zero pad
    input  wire  [uad_pkg::S_TUSER_W-1:0]   s_tuser,  // kind[1:0]
    output logic                            cmd_valid,
    input  wire                             cmd_ready,
    output uad_pkg::cmd_t                   cmd
);
    import uad_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [VAL_W-1:0] in_value;
    logic [1:0]       in_size;
    logic             in_alt;
    logic [1:0]       in_kind;
    cmd_t             cls;

    cmd_t             q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop;

    assign in_value = s_tdata[VAL_W-1:0];
    assign in_size  = s_tdata[VAL_W+1:VAL_W];
    assign in_alt   = s_tdata[VAL_W+2];
    assign in_kind  = s_tuser;

    // classify: cut to length, pick decimal step count, decide on prefix
    always_comb
    begin
        cls.kind = in_kind;
        case (in_size)
            SIZE_16:
            begin
                cls.value = {48'd0, in_value[15:0]};
                cls.steps = STEPS_16;
            end
            SIZE_64:
            begin
                cls.value = in_value;
                cls.steps = STEPS_64;
            end
            default:
            begin
                cls.value = {32'd0, in_value[31:0]};
                cls.steps = STEPS_32;
            end
        endcase
        cls.prefix = in_alt && (cls.value != '0) && (in_kind != KIND_DEC);
    end

    // command queue
    assign s_tready  = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

>>> design/uad_back.sv
// ----------------------------------------------------------------------------
// uad_back
// Converts one queued command to digits and sends the characters out.
// ----------------------------------------------------------------------------
`default_nettype none

module uad_back (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cmd_valid,
    output logic                            cmd_ready,
    input  uad_pkg::cmd_t                   cmd,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [uad_pkg::M_TDATA_W-1:0]   m_tdata,  // char_out[7:0]
    output logic                            m_tlast
);
    import uad_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DABBLE   = 3'd1;
    localparam logic [2:0] ST_PFX_ZERO = 3'd2;
    localparam logic [2:0] ST_PFX_X    = 3'd3;
    localparam logic [2:0] ST_DIGITS   = 3'd4;

    logic [2:0]        state_reg,   state_next;
    logic [DIG_W-1:0]  digs_reg,    digs_next;
    logic [VAL_W-1:0]  val_reg,     val_next;
    logic [STEP_W-1:0] steps_reg,   steps_next;
    logic [REM_W-1:0]  rem_reg,     rem_next;
    logic              started_reg, started_next;
    logic [1:0]        kind_reg,    kind_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_char_reg,  out_char_next;
    logic              out_last_reg,  out_last_next;

    logic              out_free;
    logic [3:0]        top;
    logic [7:0]        top_char;
    logic [DIG_W-1:0]  dabbled;
    logic [DIG_W-1:0]  oct_digs;
    logic [DIG_W-1:0]  hex_digs;
    logic [VAL_W+1:0]  oct_val;

    assign out_free = !out_valid_reg || m_tready;
    assign top      = digs_reg[DIG_W-1 -: 4];

    // digit to character
    always_comb
    begin
        if (top < 4'd10)
        begin
            top_char = ASCII_ZERO + {4'd0, top};
        end
        else if (kind_reg == KIND_HEXU)
        begin
            top_char = ASCII_UA + {4'd0, top} - 8'd10;
        end
        else
        begin
            top_char = ASCII_LA + {4'd0, top} - 8'd10;
        end
    end

    // four shift-add-3 steps of binary to BCD
    always_comb
    begin
        dabbled = digs_reg;
        for (int b = 0; b < 4; b++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (dabbled[4*d +: 4] >= 4'd5)
                begin
                    dabbled[4*d +: 4] = dabbled[4*d +: 4] + 4'd3;
                end
            end
            dabbled = {dabbled[DIG_W-2:0], val_reg[VAL_W-1-b]};
        end
    end

    // octal and hex digits straight from the bits
    assign oct_val = {2'b00, cmd.value};

    always_comb
    begin
        oct_digs = '0;
        hex_digs = '0;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            oct_digs[4*d +: 4] = {1'b0, oct_val[3*d +: 3]};
        end
        for (int d = 0; d < VAL_W / 4; d++)
        begin
            hex_digs[4*d +: 4] = cmd.value[4*d +: 4];
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        digs_next      = digs_reg;
        val_next       = val_reg;
        steps_next     = steps_reg;
        rem_next       = rem_reg;
        started_next   = started_reg;
        kind_next      = kind_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        cmd_ready      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    kind_next    = cmd.kind;
                    steps_next   = cmd.steps;
                    rem_next     = REM_W'(NUM_DIGITS);
                    started_next = 1'b0;
                    case (cmd.kind)
                        KIND_DEC:
                        begin
                            digs_next  = '0;
                            state_next = ST_DABBLE;
                            // left-align the kept bits for the shift-in
                            if (cmd.steps == STEPS_16)
                            begin
                                val_next = {cmd.value[15:0], 48'd0};
                            end
                            else if (cmd.steps == STEPS_32)
                            begin
                                val_next = {cmd.value[31:0], 32'd0};
                            end
                            else
                            begin
                                val_next = cmd.value;
                            end
                        end
                        KIND_OCT:
                        begin
                            digs_next  = oct_digs;
                            state_next = cmd.prefix ? ST_PFX_ZERO : ST_DIGITS;
                        end
                        default:
                        begin
                            digs_next  = hex_digs;
                            state_next = cmd.prefix ? ST_PFX_ZERO : ST_DIGITS;
                        end
                    endcase
                end
            end

            ST_DABBLE:
            begin
                digs_next  = dabbled;
                val_next   = {val_reg[VAL_W-5:0], 4'd0};
                steps_next = steps_reg - 1'b1;
                if (steps_reg == STEPS_64 - (STEPS_64 - 5'd1))
                begin
                    state_next = ST_DIGITS;
                end
            end

            ST_PFX_ZERO:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ASCII_ZERO;
                    out_last_next  = 1'b0;
                    state_next     = (kind_reg == KIND_OCT) ? ST_DIGITS : ST_PFX_X;
                end
            end

            ST_PFX_X:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = (kind_reg == KIND_HEXU) ? ASCII_UX : ASCII_LX;
                    out_last_next  = 1'b0;
                    state_next     = ST_DIGITS;
                end
            end

            ST_DIGITS:
            begin
                if (!started_reg && (top == 4'd0) && (rem_reg > REM_W'(1)))
                begin
                    // drop leading zeros, four at a time where possible
                    if ((digs_reg[DIG_W-1 -: 16] == '0) && (rem_reg > REM_W'(4)))
                    begin
                        digs_next = {digs_reg[DIG_W-17:0], 16'd0};
                        rem_next  = rem_reg - REM_W'(4);
                    end
                    else
                    begin
                        digs_next = {digs_reg[DIG_W-5:0], 4'd0};
                        rem_next  = rem_reg - 1'b1;
                    end
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = top_char;
                    out_last_next  = (rem_reg == REM_W'(1));
                    digs_next      = {digs_reg[DIG_W-5:0], 4'd0};
                    rem_next       = rem_reg - 1'b1;
                    started_next   = 1'b1;
                    if (rem_reg == REM_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and output payload registers
    always_ff @(posedge clk)
    begin
        digs_reg     <= digs_next;
        val_reg      <= val_next;
        steps_reg    <= steps_next;
        rem_reg      <= rem_next;
        started_reg  <= started_next;
        kind_reg     <= kind_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> design/unsigned_to_ascii_digits.sv
// Flow: an input word is queued; the digit sequencer then takes it, runs the binary-to-BCD
// steps for decimal of 16, 32 or 64 bits, skips leading zeros and sends the characters
// through the output register.
// The digit sequencer takes a new command only after the last character of the one
// before it; the queue can accept further input words meanwhile.
// Reset: rst_n asynchronous, active low; clears the queue and output valid.
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits
// Prints an unsigned value in decimal, octal or hex, one character per word.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_to_ascii_digits #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [uad_pkg::S_TDATA_W-1:0]   s_tdata,  // value[63:0], size_mode[65:64],
                                                      // alt_form[66], zero pad
    input  wire  [uad_pkg::S_TUSER_W-1:0]   s_tuser,  // kind[1:0]
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [uad_pkg::M_TDATA_W-1:0]   m_tdata,  // char_out[7:0]
    output logic                            m_tlast   // last
);
    import uad_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // classify and queue
    uad_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // convert and emit
    uad_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

>>> design/uad_checker.sv
// ----------------------------------------------------------------------------
// uad_checker
// Port-level checks on the character stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "unsigned_to_ascii_digits_macros.svh"

module uad_checker (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             m_tvalid,
    input  wire                             m_tready,
    input  wire  [uad_pkg::M_TDATA_W-1:0]   m_tdata,  // char_out[7:0]
    input  wire                             m_tlast
);
    import uad_pkg::*;

    logic stall;
    logic is_x;
    logic char_ok;

    // decoded views of the output word
    assign stall   = m_tvalid && !m_tready;
    assign is_x    = (m_tdata == ASCII_LX) || (m_tdata == ASCII_UX);
    assign char_ok = (m_tdata >= ASCII_ZERO && m_tdata <= ASCII_NINE) ||
                     (m_tdata >= ASCII_LA && m_tdata <= ASCII_LF) ||
                     (m_tdata >= ASCII_UA && m_tdata <= ASCII_UF) || is_x;

    // a stalled word holds
    `UAD_ASSERT(a_out_hold, clk, rst_n, stall |=> m_tvalid && $stable({m_tdata, m_tlast}), "stalled word changed")

    // nothing is shown while reset is held
    `UAD_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |-> !m_tvalid, "output valid during reset")

    // only digits, hex letters and the prefix letter ever come out
    `UAD_ASSERT(a_char_set, clk, rst_n, m_tvalid |-> char_ok, "character outside the digit set")

    // a prefix letter is never the final character
    `UAD_ASSERT(a_x_not_last, clk, rst_n, m_tvalid && m_tlast |-> !is_x, "prefix letter marked last")

endmodule

bind unsigned_to_ascii_digits uad_checker u_uad_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
